// ----- rtl/prld_pkg.sv -----
// Shared widths and constants of the pixel run-length decoder.
package prld_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PixelW  = 32;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CfgW    = 3;
  localparam int unsigned PartW   = 24;

  // Input stream payload: data_byte only (last_byte travels as tlast).
  localparam int unsigned InDataW  = ByteW;
  // Output stream payload: pixel_value, repeat_count (40 bits, whole bytes).
  localparam int unsigned OutDataW = PixelW + CountW;

  // Added to the low header bits of a run header.
  localparam int unsigned RunBiasC = 3;

  typedef logic [ByteW-1:0]    byte_t;
  typedef logic [PixelW-1:0]   pixel_t;
  typedef logic [CountW-1:0]   count_t;
  typedef logic [CfgW-1:0]     cfg_t;
  typedef logic [OutDataW-1:0] out_data_t;

endpackage

// ----- rtl/pixel_run_length_decoder_unit.sv -----
// Top level of the pixel run-length decoder: header parsing, pixel assembly, output register.
//
//  channel  | dir | handshake                       | payload
//  ---------+-----+---------------------------------+-------------------------------------
//  s_axis   | in  | s_axis_tvalid_i / s_axis_tready_o | tdata: data_byte; tlast: last_byte
//  m_axis   | out | m_axis_tvalid_o / m_axis_tready_i | tdata: pixel_value, repeat_count;
//           |     |                                 | tlast: stream_end; tuser: truncated
//  cfg      | in  | cfg_we_i (no wait)              | cfg_wdata_i: pixel_bytes
//
// One compressed byte per cycle while no result waits on a stalled output. A byte is
// decoded in the cycle it is accepted and its result (if any) sits in the output register
// on the next cycle. The output register is the only buffer: s_axis_tready_o drops
// only while a result waits there and m_axis_tready_i is low.
// rst_ni is asynchronous and active low; after it the decoder expects a header byte
// and pixel_bytes is 4.
module pixel_run_length_decoder_unit #(
  parameter int unsigned RUN_FLAG        = 128,  // header bit that marks a run
  parameter int unsigned MAX_PIXEL_BYTES = 4     // widest pixel, 1..4 bytes
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  prld_pkg::cfg_t            cfg_wdata_i,      // pixel_bytes
  // compressed byte stream
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  prld_pkg::byte_t           s_axis_tdata_i,   // [7:0] data_byte
  input  logic                      s_axis_tlast_i,   // last_byte
  // decoded pixel stream
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output prld_pkg::out_data_t       m_axis_tdata_o,   // [31:0] pixel_value, [39:32] repeat_count
  output logic                      m_axis_tlast_o,   // stream_end
  output logic                      m_axis_tuser_o    // [0] truncated
);

  import prld_pkg::*;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhRun     = 2'd1,
    PhLiteral = 2'd2
  } phase_e;

  localparam byte_t RunFlagC  = byte_t'(RUN_FLAG);
  localparam cfg_t  MaxBytesC = cfg_t'(MAX_PIXEL_BYTES);

  // Decoder state
  phase_e             phase_q, phase_d;
  logic [1:0]         pos_q, pos_d;
  count_t             remain_q, remain_d;
  logic [PartW-1:0]   partial_q, partial_d;
  count_t             run_len_q, run_len_d;
  cfg_t               pixel_bytes_q;

  // Output register
  logic               out_valid_q;
  pixel_t             out_pixel_q;
  count_t             out_count_q;
  logic               out_end_q;
  logic               out_trunc_q;

  logic               accept;
  logic               emit;
  logic               have_pixel;
  pixel_t             value;
  count_t             count;
  logic               trunc;
  cfg_t               width;
  pixel_t             assembled;
  logic               pixel_done;
  logic [ByteW:0]     run_sum;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    // Out-of-range widths clamp into 1..MAX_PIXEL_BYTES.
    width = pixel_bytes_q;
    if (width == '0) begin
      width = cfg_t'(1);
    end
    if (width > MaxBytesC) begin
      width = MaxBytesC;
    end

    assembled  = {{(PixelW-PartW){1'b0}}, partial_q}
               | ({{(PixelW-ByteW){1'b0}}, s_axis_tdata_i} << {pos_q, 3'b000});
    pixel_done = ({1'b0, pos_q} + cfg_t'(1)) >= width;

    // Run count, saturating when a narrow run flag lets it pass 255.
    run_sum = {1'b0, s_axis_tdata_i ^ RunFlagC} + (ByteW+1)'(RunBiasC);

    phase_d    = phase_q;
    pos_d      = pos_q;
    remain_d   = remain_q;
    partial_d  = partial_q;
    run_len_d  = run_len_q;
    have_pixel = 1'b0;
    value      = '0;
    count      = '0;

    case (phase_q)
      PhRun, PhLiteral: begin
        if (pixel_done) begin
          have_pixel = 1'b1;
          value      = assembled;
          pos_d      = '0;
          partial_d  = '0;
          if (phase_q == PhRun) begin
            count   = run_len_q;
            phase_d = PhHeader;
          end else begin
            count = count_t'(1);
            if (remain_q == '0) begin
              phase_d = PhHeader;
            end else begin
              remain_d = remain_q - count_t'(1);
            end
          end
        end else begin
          partial_d = assembled[PartW-1:0];
          pos_d     = pos_q + 2'd1;
        end
      end
      default: begin
        pos_d     = '0;
        partial_d = '0;
        if ((s_axis_tdata_i & RunFlagC) != '0) begin
          run_len_d = run_sum[ByteW] ? {CountW{1'b1}} : run_sum[CountW-1:0];
          phase_d   = PhRun;
        end else begin
          remain_d = s_axis_tdata_i;
          phase_d  = PhLiteral;
        end
      end
    endcase

    // Stream ended in a header, inside a pixel, or before a literal block finished.
    trunc = s_axis_tlast_i && (!have_pixel || phase_d != PhHeader);
    emit  = have_pixel || s_axis_tlast_i;

    // The last byte leaves the decoder ready for a new stream.
    if (s_axis_tlast_i) begin
      phase_d   = PhHeader;
      pos_d     = '0;
      remain_d  = '0;
      partial_d = '0;
      run_len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhHeader;
      pos_q         <= '0;
      remain_q      <= '0;
      partial_q     <= '0;
      run_len_q     <= '0;
      pixel_bytes_q <= cfg_t'(4);
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pixel_bytes_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        remain_q  <= remain_d;
        partial_q <= partial_d;
        run_len_q <= run_len_d;
      end
      if (accept && emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload of the output register, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_pixel_q <= value;
      out_count_q <= count;
      out_end_q   <= s_axis_tlast_i;
      out_trunc_q <= trunc;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_count_q, out_pixel_q};
  assign m_axis_tlast_o  = out_end_q;
  assign m_axis_tuser_o  = out_trunc_q;

endmodule

// ----- rtl/prld_checker.sv -----
// Port-level assertions for the pixel run-length decoder, bound to the top level.
module prld_port_props (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input prld_pkg::out_data_t   m_axis_tdata_o,
  input logic                  m_axis_tlast_o,
  input logic                  m_axis_tuser_o
);

  import prld_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)
      && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // Input side stalls only behind a waiting result.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a waiting result");

  // A zero count is only the bare end marker of a truncated stream.
  a_end_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[OutDataW-1:PixelW] == '0) |->
      m_axis_tlast_o && m_axis_tuser_o && (m_axis_tdata_o[PixelW-1:0] == '0))
    else $error("zero count outside an end marker");

  // Truncation is reported only at the end of a stream.
  a_trunc_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("truncated flag without stream end");

endmodule

bind pixel_run_length_decoder_unit prld_port_props u_prld_port_props (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
